// ----- rtl/segment_display_two_wire_driver_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-wire segment display driver
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DISPLAY_TWO_WIRE_DRIVER_ASSERT_SVH
`define SEGMENT_DISPLAY_TWO_WIRE_DRIVER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define SDTW_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SDTW_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/sdtw_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtw_pkg
// Word types, operation codes and fixed bytes of the two-wire display driver.
// ----------------------------------------------------------------------------
package sdtw_pkg;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [7:0] CTRL_RESET_VALUE = 8'h88;
    localparam logic [7:0] CMD_DATA_WRITE   = 8'h40;
    localparam logic [7:0] CMD_ADDR_SET     = 8'hC0;

    typedef struct packed {
        logic       operation;
        logic [3:0] digit_zero;
        logic [3:0] digit_one;
        logic [3:0] digit_two;
        logic [3:0] digit_three;
        logic       colon_on;
        logic       data_in;
    } in_word_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic data_drive_enable;
        logic busy_res;
        logic ack_fault;
        logic frame_done;
    } out_word_t;

    // Digits ten and above show blank.
    function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/segment_display_two_wire_driver.sv -----
// An accepted word is registered in the input stage, and its result word in the output stage.
// One word per cycle unless out_ready stalls; the sequencer updates its state once per word.
// Stalls on the result side hold one word in the input register, then drop in_ready.
// Reset (rst_n low, asynchronous): pins idle high, no sequence running, control
// byte set to 0x88 and marked for sending before the next frame sequence.
// ----------------------------------------------------------------------------
// segment_display_two_wire_driver
// Bit-banged two-wire seven-segment display driver with valid/ready channels.
// ----------------------------------------------------------------------------
module segment_display_two_wire_driver
    import sdtw_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data
);

    logic      item_valid;
    in_word_t  item;
    logic      fire;
    out_word_t result;

    sdtw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sdtw_sequencer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_sequencer (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .result         (result)
    );

    sdtw_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .fire       (fire),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

endmodule

// ----- rtl/sdtw_in_stage.sv -----
// ----------------------------------------------------------------------------
// sdtw_in_stage
// Input register: holds one accepted word until the sequencer takes it.
// ----------------------------------------------------------------------------
module sdtw_in_stage
    import sdtw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     take,
    output logic     item_valid,
    output in_word_t item
);

    logic     item_valid_reg;
    logic     item_valid_next;
    in_word_t item_reg;

    assign in_ready = !item_valid_reg || take;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_word;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/sdtw_sequencer.sv -----
// ----------------------------------------------------------------------------
// sdtw_sequencer
// Frame sequencer: moves the pin waveform one step per tick word; an update word starts a sequence while idle.
// ----------------------------------------------------------------------------
module sdtw_sequencer
    import sdtw_pkg::*;
#(
    parameter int DIGIT_COUNT = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_word_t   item,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    output out_word_t  result
);

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_START    = 3'd1;
    localparam logic [2:0] PH_CLK_LOW  = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_CLK_HIGH = 3'd4;
    localparam logic [2:0] PH_ACK      = 3'd5;
    localparam logic [2:0] PH_STOP     = 3'd6;

    localparam logic [1:0] KIND_CTRL = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ADDR = 2'd2;

    localparam int          COLON_IDX  = (DIGIT_COUNT > 1) ? 1 : 0;
    localparam logic [3:0]  ADDR_BYTES = 4'(1 + DIGIT_COUNT);

    logic [2:0] phase_reg,   phase_next;
    logic [3:0] bit_reg,     bit_next;
    logic [2:0] byte_reg,    byte_next;
    logic [1:0] kind_reg,    kind_next;
    logic [7:0] shift_reg,   shift_next;
    logic [7:0] ctrl_reg,    ctrl_next;
    logic       pending_reg, pending_next;
    logic       fault_reg,   fault_next;
    logic       clk_lvl_reg, clk_lvl_next;
    logic       dat_lvl_reg, dat_lvl_next;
    logic       drive_reg,   drive_next;
    logic       busy_reg,    busy_next;
    logic [7:0] seg_reg  [DIGIT_COUNT];
    logic [7:0] seg_next [DIGIT_COUNT];

    logic [3:0] digits [4];
    logic [2:0] byte_inc;
    logic [2:0] load_idx;
    logic [7:0] load_byte;
    logic [3:0] frame_len;
    logic       done;

    assign digits[0] = item.digit_zero;
    assign digits[1] = item.digit_one;
    assign digits[2] = item.digit_two;
    assign digits[3] = item.digit_three;

    assign byte_inc  = byte_reg + 3'd1;
    assign frame_len = (kind_reg == KIND_CTRL || kind_reg == KIND_DATA) ? 4'd1 : ADDR_BYTES;

    // The start step loads byte zero; the ack step loads the following byte.
    assign load_idx = (phase_reg == PH_START) ? 3'd0 : byte_inc;

    always_comb
    begin
        load_byte = 8'h00;
        if (kind_reg == KIND_CTRL)
        begin
            load_byte = ctrl_reg;
        end
        else if (kind_reg == KIND_DATA)
        begin
            load_byte = CMD_DATA_WRITE;
        end
        else if (load_idx == 3'd0)
        begin
            load_byte = CMD_ADDR_SET;
        end
        else
        begin
            for (int j = 0; j < DIGIT_COUNT; j++)
            begin
                if (load_idx == 3'(j + 1))
                begin
                    load_byte = seg_reg[j];
                end
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        kind_next    = kind_reg;
        shift_next   = shift_reg;
        ctrl_next    = ctrl_reg;
        pending_next = pending_reg;
        fault_next   = fault_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_lvl_next = dat_lvl_reg;
        drive_next   = drive_reg;
        busy_next    = busy_reg;
        seg_next     = seg_reg;
        done         = 1'b0;

        if (fire && item.operation == OP_UPDATE)
        begin
            // An update that arrives during a sequence is dropped.
            if (!busy_reg)
            begin
                for (int i = 0; i < DIGIT_COUNT; i++)
                begin
                    seg_next[i] = (i < 4) ? seg_lookup(digits[2'(i)]) : 8'h00;
                end
                if (DIGIT_COUNT > 1 && item.colon_on)
                begin
                    seg_next[COLON_IDX][7] = 1'b1;
                end
                busy_next  = 1'b1;
                kind_next  = pending_reg ? KIND_CTRL : KIND_DATA;
                bit_next   = 4'd0;
                byte_next  = 3'd0;
                phase_next = PH_START;
            end
        end
        else if (fire)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (kind_reg == KIND_CTRL)
                    begin
                        pending_next = 1'b0;
                    end
                    dat_lvl_next = 1'b0;
                    drive_next   = 1'b1;
                    byte_next    = 3'd0;
                    bit_next     = 4'd0;
                    shift_next   = load_byte;
                    phase_next   = PH_CLK_LOW;
                end
                PH_CLK_LOW:
                begin
                    clk_lvl_next = 1'b0;
                    phase_next   = PH_DATA;
                end
                PH_DATA:
                begin
                    if (bit_reg < 4'd8)
                    begin
                        dat_lvl_next = shift_reg[0];
                        drive_next   = 1'b1;
                    end
                    else
                    begin
                        drive_next = 1'b0;
                    end
                    phase_next = PH_CLK_HIGH;
                end
                PH_CLK_HIGH:
                begin
                    clk_lvl_next = 1'b1;
                    if (bit_reg < 4'd8)
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        bit_next   = bit_reg + 4'd1;
                        phase_next = PH_CLK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_ACK;
                    end
                end
                PH_ACK:
                begin
                    if (item.data_in)
                    begin
                        fault_next = 1'b1;
                    end
                    clk_lvl_next = 1'b0;
                    drive_next   = 1'b1;
                    byte_next    = byte_inc;
                    bit_next     = 4'd0;
                    if ({1'b0, byte_inc} < frame_len)
                    begin
                        shift_next = load_byte;
                        phase_next = PH_CLK_LOW;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP:
                begin
                    if (bit_reg == 4'd0)
                    begin
                        dat_lvl_next = 1'b0;
                        drive_next   = 1'b1;
                        bit_next     = 4'd1;
                    end
                    else if (bit_reg == 4'd1)
                    begin
                        clk_lvl_next = 1'b1;
                        bit_next     = 4'd2;
                    end
                    else
                    begin
                        dat_lvl_next = 1'b1;
                        drive_next   = 1'b1;
                        bit_next     = 4'd0;
                        if (kind_reg == KIND_CTRL)
                        begin
                            kind_next  = KIND_DATA;
                            phase_next = PH_START;
                        end
                        else if (kind_reg == KIND_DATA)
                        begin
                            kind_next  = KIND_ADDR;
                            phase_next = PH_START;
                        end
                        else
                        begin
                            kind_next  = KIND_CTRL;
                            busy_next  = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (cfg_write_en)
        begin
            ctrl_next    = cfg_write_data;
            pending_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_reg     <= 4'd0;
            byte_reg    <= 3'd0;
            kind_reg    <= KIND_CTRL;
            shift_reg   <= 8'h00;
            ctrl_reg    <= CTRL_RESET_VALUE;
            pending_reg <= 1'b1;
            fault_reg   <= 1'b0;
            clk_lvl_reg <= 1'b1;
            dat_lvl_reg <= 1'b1;
            drive_reg   <= 1'b1;
            busy_reg    <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                seg_reg[i] <= 8'h00;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            kind_reg    <= kind_next;
            shift_reg   <= shift_next;
            ctrl_reg    <= ctrl_next;
            pending_reg <= pending_next;
            fault_reg   <= fault_next;
            clk_lvl_reg <= clk_lvl_next;
            dat_lvl_reg <= dat_lvl_next;
            drive_reg   <= drive_next;
            busy_reg    <= busy_next;
            seg_reg     <= seg_next;
        end
    end

    assign result.clock_line        = clk_lvl_next;
    assign result.data_line         = dat_lvl_next;
    assign result.data_drive_enable = drive_next;
    assign result.busy_res          = busy_next;
    assign result.ack_fault         = fault_next;
    assign result.frame_done        = done;

endmodule

// ----- rtl/sdtw_out_stage.sv -----
// ----------------------------------------------------------------------------
// sdtw_out_stage
// Result register: holds a finished word until the consumer takes it.
// ----------------------------------------------------------------------------
module sdtw_out_stage
    import sdtw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  out_word_t result,
    output logic      fire,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;

    // A new result may load when the register is empty or draining now.
    assign fire = item_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- rtl/sdtw_checker.sv -----
// ----------------------------------------------------------------------------
// sdtw_checker
// Port-level checks on the result words of the display driver.
// ----------------------------------------------------------------------------
`include "segment_display_two_wire_driver_assert.svh"

module sdtw_checker
    import sdtw_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // The word that ends a sequence already shows the driver as free.
    `SDTW_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_valid && out_word.frame_done, !out_word.busy_res, "frame_done with busy_res set")

    // The data pin is only let go inside an ack slot of a running frame.
    `SDTW_ASSERT_NOW(a_release_in_frame, clk, rst_n, out_valid && !out_word.data_drive_enable, out_word.busy_res, "data released while idle")

    // Between sequences both lines rest high and data is driven.
    `SDTW_ASSERT_NOW(a_idle_pins_high, clk, rst_n, out_valid && !out_word.busy_res, out_word.clock_line && out_word.data_line && out_word.data_drive_enable, "idle pins not high")

    // A stalled result word holds.
    `SDTW_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed under stall")

endmodule

bind segment_display_two_wire_driver sdtw_checker u_sdtw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

// ----- tb/tb_segment_display_two_wire_driver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_display_two_wire_driver
// Drives update and tick words into the two-wire display driver with random
// gaps and output stalls, predicts every pin word and checks it field by field.
// ----------------------------------------------------------------------------
import sdtw_pkg::*;

localparam int NUM_DIGITS = 4;

typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_START    = 3'd1,
    STEP_CLK_LOW  = 3'd2,
    STEP_DATA     = 3'd3,
    STEP_CLK_HIGH = 3'd4,
    STEP_ACK      = 3'd5,
    STEP_STOP     = 3'd6
} pin_step_t;

typedef enum logic [1:0] {
    FRAME_CONTROL = 2'd0,
    FRAME_DATA    = 2'd1,
    FRAME_DIGITS  = 2'd2
} frame_kind_t;

class pin_scoreboard;
    logic [7:0]  control_byte;
    pin_step_t   step;
    logic [3:0]  bit_cnt;
    logic [2:0]  byte_cnt;
    frame_kind_t kind;
    logic [7:0]  shifter;
    logic [7:0]  glyphs [NUM_DIGITS];
    logic        control_due;
    logic        fault_seen;
    logic        clk_pin;
    logic        dat_pin;
    logic        dat_drive;
    logic        busy;
    out_word_t   expected_pins [$];
    int          results_seen;
    int          failures;

    function new();
        control_byte = CTRL_RESET_VALUE;
        step         = STEP_IDLE;
        bit_cnt      = '0;
        byte_cnt     = '0;
        kind         = FRAME_CONTROL;
        shifter      = '0;
        foreach (glyphs[i]) glyphs[i] = '0;
        control_due  = 1'b1;
        fault_seen   = 1'b0;
        clk_pin      = 1'b1;
        dat_pin      = 1'b1;
        dat_drive    = 1'b1;
        busy         = 1'b0;
        results_seen = 0;
        failures     = 0;
    endfunction

    function void write_control(logic [7:0] value);
        control_byte = value;
        control_due  = 1'b1;
    endfunction

    function logic [7:0] glyph(logic [3:0] digit);
        logic [7:0] segs;
        case (digit)
            4'd0:    segs = 8'h3F;
            4'd1:    segs = 8'h06;
            4'd2:    segs = 8'h5B;
            4'd3:    segs = 8'h4F;
            4'd4:    segs = 8'h66;
            4'd5:    segs = 8'h6D;
            4'd6:    segs = 8'h7D;
            4'd7:    segs = 8'h07;
            4'd8:    segs = 8'h7F;
            4'd9:    segs = 8'h6F;
            default: segs = 8'h00;
        endcase
        return segs;
    endfunction

    function int frame_len();
        return (kind == FRAME_CONTROL || kind == FRAME_DATA) ? 1 : 1 + NUM_DIGITS;
    endfunction

    function logic [7:0] byte_at(int idx);
        if (kind == FRAME_CONTROL)
            return control_byte;
        if (kind == FRAME_DATA)
            return CMD_DATA_WRITE;
        if (idx == 0)
            return CMD_ADDR_SET;
        if (idx - 1 < NUM_DIGITS)
            return glyphs[idx - 1];
        return 8'h00;
    endfunction

    // One pin step of the sequencer; done is raised on the step that ends the
    // last frame of a sequence.
    function void advance(logic sample, output logic done);
        done = 1'b0;
        case (step)
            STEP_START:
            begin
                if (kind == FRAME_CONTROL)
                    control_due = 1'b0;
                dat_pin   = 1'b0;
                dat_drive = 1'b1;
                byte_cnt  = '0;
                bit_cnt   = '0;
                shifter   = byte_at(0);
                step      = STEP_CLK_LOW;
            end
            STEP_CLK_LOW:
            begin
                clk_pin = 1'b0;
                step    = STEP_DATA;
            end
            STEP_DATA:
            begin
                if (bit_cnt < 8)
                begin
                    dat_pin   = shifter[0];
                    dat_drive = 1'b1;
                end
                else
                begin
                    dat_drive = 1'b0;
                end
                step = STEP_CLK_HIGH;
            end
            STEP_CLK_HIGH:
            begin
                clk_pin = 1'b1;
                if (bit_cnt < 8)
                begin
                    shifter = shifter >> 1;
                    bit_cnt = bit_cnt + 1'b1;
                    step    = STEP_CLK_LOW;
                end
                else
                begin
                    step = STEP_ACK;
                end
            end
            STEP_ACK:
            begin
                if (sample)
                    fault_seen = 1'b1;
                clk_pin   = 1'b0;
                dat_drive = 1'b1;
                byte_cnt  = byte_cnt + 1'b1;
                bit_cnt   = '0;
                if (int'(byte_cnt) < frame_len())
                begin
                    shifter = byte_at(int'(byte_cnt));
                    step    = STEP_CLK_LOW;
                end
                else
                begin
                    step = STEP_STOP;
                end
            end
            STEP_STOP:
            begin
                if (bit_cnt == 0)
                begin
                    dat_pin   = 1'b0;
                    dat_drive = 1'b1;
                    bit_cnt   = 4'd1;
                end
                else if (bit_cnt == 1)
                begin
                    clk_pin = 1'b1;
                    bit_cnt = 4'd2;
                end
                else
                begin
                    dat_pin   = 1'b1;
                    dat_drive = 1'b1;
                    bit_cnt   = '0;
                    if (kind == FRAME_CONTROL)
                    begin
                        kind = FRAME_DATA;
                        step = STEP_START;
                    end
                    else if (kind == FRAME_DATA)
                    begin
                        kind = FRAME_DIGITS;
                        step = STEP_START;
                    end
                    else
                    begin
                        kind = FRAME_CONTROL;
                        busy = 1'b0;
                        step = STEP_IDLE;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void note_input(in_word_t w);
        logic [3:0] digits [4];
        logic       done;
        out_word_t  pins;
        done = 1'b0;
        if (w.operation == OP_UPDATE)
        begin
            // An update that arrives mid-sequence is dropped.
            if (!busy)
            begin
                digits[0] = w.digit_zero;
                digits[1] = w.digit_one;
                digits[2] = w.digit_two;
                digits[3] = w.digit_three;
                for (int i = 0; i < NUM_DIGITS; i++)
                    glyphs[i] = (i < 4) ? glyph(digits[i]) : 8'h00;
                if (NUM_DIGITS > 1 && w.colon_on)
                    glyphs[1 % NUM_DIGITS][7] = 1'b1;
                busy     = 1'b1;
                kind     = control_due ? FRAME_CONTROL : FRAME_DATA;
                bit_cnt  = '0;
                byte_cnt = '0;
                step     = STEP_START;
            end
        end
        else
        begin
            advance(w.data_in, done);
        end
        pins.clock_line        = clk_pin;
        pins.data_line         = dat_pin;
        pins.data_drive_enable = dat_drive;
        pins.busy_res          = busy;
        pins.ack_fault         = fault_seen;
        pins.frame_done        = done;
        expected_pins.push_back(pins);
    endfunction

    function void compare_pin(string name, logic want, logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(out_word_t got);
        out_word_t want;
        results_seen++;
        if (expected_pins.size() == 0)
        begin
            $error("result word arrived with no word outstanding");
            failures++;
            return;
        end
        want = expected_pins.pop_front();
        compare_pin("clock_line", want.clock_line, got.clock_line);
        compare_pin("data_line", want.data_line, got.data_line);
        compare_pin("data_drive_enable", want.data_drive_enable, got.data_drive_enable);
        compare_pin("busy_res", want.busy_res, got.busy_res);
        compare_pin("ack_fault", want.ack_fault, got.ack_fault);
        compare_pin("frame_done", want.frame_done, got.frame_done);
    endfunction
endclass

module tb_segment_display_two_wire_driver;
    localparam int TARGET_WORDS = 1950;
    localparam int STALL_LIMIT  = 1000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_word;
    logic       cfg_write_en;
    logic [7:0] cfg_write_data;

    pin_scoreboard board;
    int  words_sent;
    int  quiet_cycles;
    bit  calm_phase;

    segment_display_two_wire_driver #(
        .DIGIT_COUNT(NUM_DIGITS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_gap();
        return calm_phase ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic in_word_t make_word(logic op, logic [3:0] d0, logic [3:0] d1,
                                           logic [3:0] d2, logic [3:0] d3,
                                           logic colon, logic sda);
        in_word_t w;
        w.operation   = op;
        w.digit_zero  = d0;
        w.digit_one   = d1;
        w.digit_two   = d2;
        w.digit_three = d3;
        w.colon_on    = colon;
        w.data_in     = sda;
        return w;
    endfunction

    function automatic in_word_t random_update();
        return make_word(OP_UPDATE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // The digit fields of a tick are don't-care, so they carry noise too.
    function automatic in_word_t random_tick();
        in_word_t w;
        w = random_update();
        w.operation = OP_TICK;
        w.data_in   = ($urandom_range(0, 24) == 0);
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Drop in_valid and wait for every result word, then let the pipeline idle before returning.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.results_seen < words_sent) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_control(logic [7:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        board.write_control(value);
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // An update followed by ticks; some sequences are cut short and some
    // ticks are swapped for updates that land while the driver is busy.
    task automatic run_sequence();
        int ticks;
        ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 200) : $urandom_range(180, 230);
        send_word(random_update());
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_word(random_update());
            else
                send_word(random_tick());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_input(in_word);
            if (out_valid && out_ready)
                board.check_result(out_word);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("FAIL segment_display_two_wire_driver");
        $finish;
    end

    initial
    begin
        logic [7:0] ctrl;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_word        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        board          = new();
        words_sent     = 0;
        quiet_cycles   = 0;
        calm_phase     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        @(posedge clk);

        // Tick while idle, then extreme digits with the colon, then an update
        // that arrives while busy, then the start of the control frame.
        send_word(make_word(OP_TICK, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1));
        send_word(make_word(OP_UPDATE, 4'd0, 4'd9, 4'd10, 4'd15, 1'b1, 1'b0));
        send_word(make_word(OP_UPDATE, 4'd8, 4'd8, 4'd8, 4'd8, 1'b0, 1'b1));
        for (int i = 0; i < 20; i++)
            send_word(make_word(OP_TICK, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0, 1'(i % 2)));
        drain();
        // Written mid-sequence: it must wait for the next sequence.
        write_control(8'd128);

        for (int phase = 0; words_sent < TARGET_WORDS; phase++)
        begin
            calm_phase = ($urandom_range(0, 3) == 0);
            if (phase < 3 || $urandom_range(0, 2) != 0)
            begin
                case (phase)
                    0:       ctrl = 8'd143;
                    1:       ctrl = 8'd0;
                    2:       ctrl = 8'd255;
                    default: ctrl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                : 8'($urandom_range(128, 143));
                endcase
                write_control(ctrl);
            end
            run_sequence();
            drain();
        end

        repeat (8) @(posedge clk);
        if (board.failures == 0 && board.expected_pins.size() == 0)
            $display("PASS segment_display_two_wire_driver");
        else
            $display("FAIL segment_display_two_wire_driver");
        $finish;
    end
endmodule
